FILE: design/ook_pulse_width_code_sender_core_macros.svh
// Assertion macros shared by the pulse-width code sender RTL.
`ifndef OOK_PULSE_WIDTH_CODE_SENDER_CORE_MACROS_SVH
`define OOK_PULSE_WIDTH_CODE_SENDER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define OOKPW_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define OOKPW_NEVER(lbl, ck, rn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define OOKPW_ASSERT(lbl, ck, rn, prop, msg)
`define OOKPW_NEVER(lbl, ck, rn, cond, msg)
`endif
`endif

FILE: design/ookpw_pkg.sv
// Types and constants of the pulse-width code sender.
package ookpw_pkg;

	localparam int TICK_W = 16;
	localparam int REP_W = 4;
	localparam int PRE_W = 17;
	localparam int CODE_W = 8;
	localparam int APB_DW = 32;
	localparam int APB_AW = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [TICK_W-1:0] SHORT_RST = 16'd380;
	localparam logic [TICK_W-1:0] LONG_RST = 16'd770;
	localparam logic [TICK_W-1:0] GAP_RST = 16'd8000;
	localparam logic [REP_W-1:0] REPEAT_RST = 4'd6;
	localparam logic [PRE_W-1:0] PREAMBLE_RST = 17'b00110000111111101;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SHORT = 3'd0,
		REG_LONG = 3'd1,
		REG_GAP = 3'd2,
		REG_REPEAT = 3'd3,
		REG_PREAMBLE = 3'd4
	} reg_idx_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_START = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_LOW = 4'b0010,
		PH_HIGH = 4'b0100,
		PH_GAP = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [TICK_W-1:0] short_ticks;
		logic [TICK_W-1:0] long_ticks;
		logic [TICK_W-1:0] gap_ticks;
		logic [REP_W-1:0] repeat_count;
		logic [PRE_W-1:0] preamble_word;
	} cfg_t;

	typedef struct packed {
		logic pin_level;
		logic busy_res;
		logic finished;
	} res_t;

endpackage

FILE: design/ookpw_regs.sv
// Configuration register file with its APB-style access port.
module ookpw_regs
	import ookpw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;
	assign idx = reg_idx_t'(paddr[APB_AW-1:2]);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_ticks <= SHORT_RST;
			cfg_q.long_ticks <= LONG_RST;
			cfg_q.gap_ticks <= GAP_RST;
			cfg_q.repeat_count <= REPEAT_RST;
			cfg_q.preamble_word <= PREAMBLE_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_SHORT: cfg_q.short_ticks <= pwdata[TICK_W-1:0];
				REG_LONG: cfg_q.long_ticks <= pwdata[TICK_W-1:0];
				REG_GAP: cfg_q.gap_ticks <= pwdata[TICK_W-1:0];
				REG_REPEAT: cfg_q.repeat_count <= pwdata[REP_W-1:0];
				REG_PREAMBLE: cfg_q.preamble_word <= pwdata[PRE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SHORT: prdata = APB_DW'(cfg_q.short_ticks);
			REG_LONG: prdata = APB_DW'(cfg_q.long_ticks);
			REG_GAP: prdata = APB_DW'(cfg_q.gap_ticks);
			REG_REPEAT: prdata = APB_DW'(cfg_q.repeat_count);
			REG_PREAMBLE: prdata = APB_DW'(cfg_q.preamble_word);
			default: prdata = '0;
		endcase
	end

endmodule

FILE: design/ookpw_seq.sv
// Frame sequencer: phase, period counter, bit index and repeat counter.
`include "ook_pulse_width_code_sender_core_macros.svh"
module ookpw_seq
	import ookpw_pkg::*;
#(
	parameter int PREAMBLE_BITS = 17,
	parameter int CODE_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              start,
	input  logic [CODE_W-1:0] code,
	input  cfg_t              cfg,
	output res_t              res
);

	localparam int TOTAL = PREAMBLE_BITS + CODE_BITS;
	localparam int BW = $clog2(TOTAL + 1);
	localparam int IW = $clog2(TOTAL);
	localparam int PW = (PREAMBLE_BITS > PRE_W) ? PREAMBLE_BITS : PRE_W;
	localparam int CW = (CODE_BITS > CODE_W) ? CODE_BITS : CODE_W;
	localparam logic [BW-1:0] TOTAL_IDX = BW'(TOTAL);

	phase_t phase_q, phase_d;
	logic [TICK_W-1:0] tick_q, tick_d;
	logic [BW-1:0] idx_q, idx_d, nxt_idx;
	logic [REP_W-1:0] rep_q, rep_d, rep_inc;
	logic [CODE_W-1:0] code_q, code_d;
	logic fin;
	logic [PW-1:0] pre_ext;
	logic [CW-1:0] code_ext;
	logic [TOTAL-1:0] frame;

	assign pre_ext = PW'(cfg.preamble_word);
	assign code_ext = CW'(code_q);
	assign nxt_idx = idx_q + BW'(1);
	assign rep_inc = rep_q + REP_W'(1);

	// frame[i] is the bit sent i-th in the frame
	always_comb begin
		for (int i = 0; i < PREAMBLE_BITS; i++) begin
			frame[i] = pre_ext[PREAMBLE_BITS-1-i];
		end
		for (int j = 0; j < CODE_BITS; j++) begin
			frame[PREAMBLE_BITS+j] = code_ext[CODE_BITS-1-j];
		end
	end

	always_comb begin
		phase_d = phase_q;
		tick_d = tick_q;
		idx_d = idx_q;
		rep_d = rep_q;
		code_d = code_q;
		fin = 1'b0;
		if (advance) begin
			if (start) begin
				if (phase_q == PH_IDLE) begin
					code_d = code;
					rep_d = '0;
					idx_d = '0;
					phase_d = PH_LOW;
					tick_d = frame[0] ? cfg.short_ticks : cfg.long_ticks;
				end
			end else if (phase_q != PH_IDLE) begin
				if (tick_q > TICK_W'(1)) begin
					tick_d = tick_q - TICK_W'(1);
				end else begin
					unique case (phase_q)
						PH_LOW: begin
							phase_d = PH_HIGH;
							tick_d = frame[idx_q[IW-1:0]] ? cfg.long_ticks
								: cfg.short_ticks;
						end
						PH_HIGH: begin
							idx_d = nxt_idx;
							if (nxt_idx < TOTAL_IDX) begin
								phase_d = PH_LOW;
								tick_d = frame[nxt_idx[IW-1:0]] ? cfg.short_ticks
									: cfg.long_ticks;
							end else begin
								phase_d = PH_GAP;
								tick_d = cfg.gap_ticks;
							end
						end
						PH_GAP: begin
							rep_d = rep_inc;
							idx_d = '0;
							if (rep_inc >= cfg.repeat_count) begin
								phase_d = PH_IDLE;
								tick_d = '0;
								fin = 1'b1;
							end else begin
								phase_d = PH_LOW;
								tick_d = frame[0] ? cfg.short_ticks : cfg.long_ticks;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	assign res.pin_level = (phase_d == PH_HIGH);
	assign res.busy_res = (phase_d != PH_IDLE);
	assign res.finished = fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
			idx_q <= '0;
			rep_q <= '0;
			code_q <= '0;
		end else begin
			phase_q <= phase_d;
			tick_q <= tick_d;
			idx_q <= idx_d;
			rep_q <= rep_d;
			code_q <= code_d;
		end
	end

	`OOKPW_NEVER(a_idle_idx, clk, arst_n, (phase_q == PH_IDLE) && (idx_q != '0),
		"bit index not cleared while idle")
	`OOKPW_ASSERT(a_gap_idx, clk, arst_n, (phase_q == PH_GAP) |-> (idx_q == TOTAL_IDX),
		"frame gap entered before the last bit")
	`OOKPW_ASSERT(a_fin_idle, clk, arst_n, res.finished |=> (phase_q == PH_IDLE),
		"sequence finished but sender still busy")

endmodule

FILE: design/ook_pulse_width_code_sender_core.sv
// Top level of the pulse-width code sender: streams, output buffer, config port.
// One input transaction is taken per clock unless the slave side stalls: each tick or start
// updates the sequencer state in the cycle it is accepted, and its result is registered into
// the output buffer and offered on the master side, for a throughput of one item per cycle. A
// two-entry output buffer lets the slave side keep accepting while one result waits; the
// slave side stalls only when both entries are full. Start pulls a code in; every tick after
// it counts one microsecond of the current low period, high period or frame gap, and the
// result carries the pin level, a busy flag, and tlast on the tick that ends the last repeat.
`include "ook_pulse_width_code_sender_core_macros.svh"
module ook_pulse_width_code_sender_core
	import ookpw_pkg::*;
#(
	parameter int PREAMBLE_BITS = 17,
	parameter int CODE_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,  // [7:0] function_code
	input  logic [0:0]        s_axis_tuser,  // [0] opcode
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // [0] pin_level, [1] busy_res, [7:2] zero
	output logic              m_axis_tlast,  // finished
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;
	res_t res;
	res_t out_q, skid_q;
	logic out_vld_q, skid_vld_q;
	logic push, pop;

	ookpw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ookpw_seq #(
		.PREAMBLE_BITS (PREAMBLE_BITS),
		.CODE_BITS     (CODE_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (push),
		.start   (op_t'(s_axis_tuser[0]) == OP_START),
		.code    (s_axis_tdata[CODE_W-1:0]),
		.cfg     (cfg),
		.res     (res)
	);

	assign s_axis_tready = ~skid_vld_q;
	assign push = s_axis_tvalid & s_axis_tready;
	assign pop = out_vld_q & m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {6'b0, out_q.busy_res, out_q.pin_level};
	assign m_axis_tlast = out_q.finished;

	`OOKPW_ASSERT(a_skid_order, clk, arst_n, skid_vld_q |-> out_vld_q,
		"held result without a result on offer")

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the pulse-width code sender core: stream traffic, APB setup, predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ookpw_pkg::*;

	localparam int NUM_BITS = PRE_W + CODE_W;
	localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned HOLD_AT = 300;
	localparam int unsigned RANDOM_ITEMS = 150;

	typedef struct packed {
		op_t op;
		logic [CODE_W-1:0] code;
	} item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;  // [7:0] function_code
	logic [0:0] s_axis_tuser = '0;  // [0] opcode
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;       // [0] pin_level, [1] busy_res, [7:2] zero
	logic m_axis_tlast;             // finished
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	cfg_t cfg_m;
	phase_t ph_m;
	logic [TICK_W-1:0] left_m;
	logic [4:0] idx_m;
	logic [REP_W-1:0] reps_m;
	logic [CODE_W-1:0] code_m;

	item_t pending_q[$];
	res_t pulse_q[$];
	item_t cur_item;
	int unsigned in_count = 0;
	int unsigned err_count = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;
	longint unsigned cycle_count = 0;

	ook_pulse_width_code_sender_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic frame_bit(logic [4:0] i);
		if (i < PRE_W)
			return cfg_m.preamble_word[PRE_W-1-i];
		return code_m[CODE_W-1-(i-PRE_W)];
	endfunction

	function automatic void load_low();
		ph_m = PH_LOW;
		left_m = frame_bit(idx_m) ? cfg_m.short_ticks : cfg_m.long_ticks;
	endfunction

	function automatic res_t advance_sender(item_t it);
		res_t r;
		r.finished = 1'b0;
		if (it.op == OP_START) begin
			if (ph_m == PH_IDLE) begin
				code_m = it.code;
				reps_m = '0;
				idx_m = '0;
				load_low();
			end
		end else if (ph_m != PH_IDLE) begin
			if (left_m > 1) begin
				left_m--;
			end else begin
				case (ph_m)
					PH_LOW: begin
						ph_m = PH_HIGH;
						left_m = frame_bit(idx_m) ? cfg_m.long_ticks : cfg_m.short_ticks;
					end
					PH_HIGH: begin
						idx_m++;
						if (idx_m < NUM_BITS) begin
							load_low();
						end else begin
							ph_m = PH_GAP;
							left_m = cfg_m.gap_ticks;
						end
					end
					default: begin
						reps_m++;
						idx_m = '0;
						if (reps_m >= cfg_m.repeat_count) begin
							ph_m = PH_IDLE;
							left_m = '0;
							r.finished = 1'b1;
						end else begin
							load_low();
						end
					end
				endcase
			end
		end
		r.pin_level = (ph_m == PH_HIGH);
		r.busy_res = (ph_m != PH_IDLE);
		return r;
	endfunction

	// calm stretches of 64 transactions out of every 256
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (in_count[7:6] == 2'b00)
			return 0;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(20, 8);
	endfunction

	function automatic int unsigned run_ticks();
		int unsigned s, l, g, r;
		s = (cfg_m.short_ticks == 0) ? 1 : cfg_m.short_ticks;
		l = (cfg_m.long_ticks == 0) ? 1 : cfg_m.long_ticks;
		g = (cfg_m.gap_ticks == 0) ? 1 : cfg_m.gap_ticks;
		r = (cfg_m.repeat_count == 0) ? 1 : cfg_m.repeat_count;
		return r * (NUM_BITS * (s + l) + g);
	endfunction

	function automatic void push_item(op_t op, logic [CODE_W-1:0] code);
		item_t it;
		it.op = op;
		it.code = code;
		pending_q.push_back(it);
	endfunction

	function automatic void queue_ticks(int unsigned n, int unsigned noise_pct);
		repeat (n) begin
			if ($urandom_range(99) < noise_pct)
				push_item(OP_START, 8'($urandom));
			push_item(OP_TICK, 8'($urandom));
		end
	endfunction

	function automatic void queue_code(logic [CODE_W-1:0] code, int unsigned noise_pct);
		push_item(OP_START, code);
		queue_ticks(run_ticks(), noise_pct);
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SHORT: cfg_m.short_ticks = val[TICK_W-1:0];
			REG_LONG: cfg_m.long_ticks = val[TICK_W-1:0];
			REG_GAP: cfg_m.gap_ticks = val[TICK_W-1:0];
			REG_REPEAT: cfg_m.repeat_count = val[REP_W-1:0];
			REG_PREAMBLE: cfg_m.preamble_word = val[PRE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [TICK_W-1:0] s, logic [TICK_W-1:0] l,
			logic [TICK_W-1:0] g, logic [REP_W-1:0] r, logic [PRE_W-1:0] p);
		write_reg(REG_SHORT, APB_DW'(s));
		write_reg(REG_LONG, APB_DW'(l));
		write_reg(REG_GAP, APB_DW'(g));
		write_reg(REG_REPEAT, APB_DW'(r));
		write_reg(REG_PREAMBLE, APB_DW'(p));
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending_q.size() != 0 || s_axis_tvalid || pulse_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic note_mismatch(string what, res_t want, res_t got);
		err_count++;
		if (err_count <= 10)
			$display("mismatch at %0t ns (%s): expected pin %b busy %b last %b, got pin %b busy %b last %b",
				$time, what, want.pin_level, want.busy_res, want.finished,
				got.pin_level, got.busy_res, got.finished);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				pulse_q.push_back(advance_sender(cur_item));
				in_count++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					s_axis_tvalid <= 1'b0;
					send_gap--;
				end else if (pending_q.size() != 0) begin
					cur_item = pending_q.pop_front();
					s_axis_tuser <= cur_item.op;
					s_axis_tdata <= cur_item.code;
					s_axis_tvalid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && in_count >= HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (m_axis_tvalid && m_axis_tready)
					recv_gap <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin : check_results
		res_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.pin_level = m_axis_tdata[0];
			got.busy_res = m_axis_tdata[1];
			got.finished = m_axis_tlast;
			if (pulse_q.size() == 0) begin
				note_mismatch("no transaction pending", '0, got);
			end else begin
				want = pulse_q.pop_front();
				if (got.pin_level !== want.pin_level || got.busy_res !== want.busy_res
						|| got.finished !== want.finished)
					note_mismatch("field", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int unsigned stop_at;
		cfg_m.short_ticks = SHORT_RST;
		cfg_m.long_ticks = LONG_RST;
		cfg_m.gap_ticks = GAP_RST;
		cfg_m.repeat_count = REPEAT_RST;
		cfg_m.preamble_word = PREAMBLE_RST;
		ph_m = PH_IDLE;
		left_m = '0;
		idx_m = '0;
		reps_m = '0;
		code_m = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		push_item(OP_TICK, 8'hFF);
		push_item(OP_TICK, 8'h00);
		wait_idle();

		set_config(16'd1, 16'd1, 16'd2, 4'd2, 17'h1FFFF);
		push_item(OP_START, 8'h00);
		push_item(OP_START, 8'hFF);
		queue_ticks(run_ticks(), 0);
		push_item(OP_TICK, 8'hA5);
		queue_code(8'hFF, 0);
		wait_idle();

		set_config(16'd1, 16'd1, 16'd1, 4'd4, 17'h00000);
		queue_code(8'hA5, 0);
		wait_idle();

		set_config(16'd3, 16'd1, 16'd2, 4'd1, 17'h0AAAA);
		queue_code(8'h5A, 0);
		wait_idle();

		stop_at = in_count + RANDOM_ITEMS;
		while (in_count < stop_at) begin
			set_config(16'($urandom_range(2, 1)), 16'($urandom_range(2, 1)),
				16'($urandom_range(4, 1)), 4'($urandom_range(2, 1)), 17'($urandom));
			repeat ($urandom_range(2, 1)) begin
				queue_ticks($urandom_range(2), 0);
				queue_code(8'($urandom), 4);
			end
			wait_idle();
		end

		// load the widest short, gap and repeat counts and tick part way into the first low period
		set_config(16'hFFFF, 16'd1, 16'hFFFF, 4'd15, 17'h1FFFF);
		push_item(OP_START, 8'h3C);
		push_item(OP_START, 8'hC3);
		queue_ticks(100, 0);
		wait_idle();

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

FILE: ook_pulse_width_code_sender_core.f
+incdir+design
design/ookpw_pkg.sv
design/ookpw_regs.sv
design/ookpw_seq.sv
design/ook_pulse_width_code_sender_core.sv
tb/sv/tb.sv
